>>> design/exp_gauss_exp_lineshape_eval_assert.svh
// ----------------------------------------------------------------------------
// ExpGaussExp evaluator assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef EXP_GAUSS_EXP_LINESHAPE_EVAL_ASSERT_SVH
`define EXP_GAUSS_EXP_LINESHAPE_EVAL_ASSERT_SVH

// property holds at every edge out of reset
`define EGL_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("egl: assertion failed");

// condition never seen out of reset
`define EGL_ASSERT_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("egl: forbidden condition seen");

`endif

>>> design/egl_pkg.sv
// ----------------------------------------------------------------------------
// egl_pkg
// Types and constants shared by the ExpGaussExp evaluator modules.
// ----------------------------------------------------------------------------
package egl_pkg;

	localparam logic [1:0] REGION_CORE  = 2'd0;
	localparam logic [1:0] REGION_LEFT  = 2'd1;
	localparam logic [1:0] REGION_RIGHT = 2'd2;

	localparam logic [2:0] CFG_NORM_GAIN   = 3'd0;
	localparam logic [2:0] CFG_PEAK_MEAN   = 3'd1;
	localparam logic [2:0] CFG_PEAK_SIGMA  = 3'd2;
	localparam logic [2:0] CFG_LEFT_SLOPE  = 3'd3;
	localparam logic [2:0] CFG_RIGHT_SLOPE = 3'd4;

	localparam logic [31:0] LN2_Q32 = 32'd2977044471;
	localparam int EXP_LIMIT    = 40;
	localparam int TAYLOR_TERMS = 13;
	localparam int RECIP_SHIFT  = 36;

	// slope-derived values, static while items are in flight
	typedef struct packed {
		logic [31:0] kl;
		logic [31:0] kr;
		logic [63:0] cl;   // ceil(kL*sigma) in Q.F
		logic [63:0] cr;
		logic [63:0] bl;   // kL*kL/2 in Q.F
		logic [63:0] br;
	} egl_shape_cfg_t;

endpackage

>>> design/egl_div.sv
// ----------------------------------------------------------------------------
// egl_div
// Restoring divider, one quotient bit per pipeline stage: t = |d|*2^F / sigma.
// ----------------------------------------------------------------------------
module egl_div #(
	parameter int F = 24
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic [31:0]     in_ad,
	input  logic [32:0]     in_d,
	input  logic [30:0]     sigma,
	output logic            out_valid,
	output logic [32+F-1:0] out_t,
	output logic [32:0]     out_d
);

	localparam int QW = 32 + F;

	typedef struct packed {
		logic [30:0]   r;
		logic [QW-1:0] n;
		logic [QW-1:0] q;
	} step_t;

	function automatic step_t div_step(step_t a, logic [30:0] s);
		step_t       o;
		logic [31:0] trial;
		trial = {a.r, a.n[QW-1]};
		o.n = a.n << 1;
		if (trial >= {1'b0, s}) begin
			o.r = 31'(trial - {1'b0, s});
			o.q = {a.q[QW-2:0], 1'b1};
		end else begin
			o.r = trial[30:0];
			o.q = {a.q[QW-2:0], 1'b0};
		end
		return o;
	endfunction

	logic        vld_s [QW];
	step_t       st_s  [QW];
	step_t       st_nx [QW];
	logic [32:0] d_s   [QW];

	always_comb begin
		st_nx[0] = div_step({31'd0, QW'(in_ad) << F, {QW{1'b0}}}, sigma);
		for (int i = 1; i < QW; i++) begin
			st_nx[i] = div_step(st_s[i-1], sigma);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < QW; i++) vld_s[i] <= 1'b0;
		end else begin
			vld_s[0] <= in_valid;
			for (int i = 1; i < QW; i++) vld_s[i] <= vld_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		d_s[0] <= in_d;
		for (int i = 1; i < QW; i++) d_s[i] <= d_s[i-1];
		for (int i = 0; i < QW; i++) st_s[i] <= st_nx[i];
	end

	assign out_valid = vld_s[QW-1];
	assign out_t     = st_s[QW-1].q;
	assign out_d     = d_s[QW-1];

endmodule

>>> design/egl_expo.sv
// ----------------------------------------------------------------------------
// egl_expo
// Region select and exponent magnitude, four stages, with underflow flag.
// ----------------------------------------------------------------------------
module egl_expo import egl_pkg::*; #(
	parameter int F = 24
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic [32+F-1:0] in_t,
	input  logic [32:0]     in_d,
	input  egl_shape_cfg_t  cfg,
	output logic            out_valid,
	output logic [F+5:0]    out_e,
	output logic            out_uf,
	output logic [1:0]      out_region
);

	localparam int QW = 32 + F;
	localparam logic [64:0] LIMIT = 65'(EXP_LIMIT) << F;

	logic signed [64:0] d_x;
	logic signed [64:0] nd_x;
	logic               is_left;
	logic               is_right;

	assign d_x      = 65'(signed'(in_d));
	assign nd_x     = -d_x;
	assign is_left  = nd_x >= $signed({1'b0, cfg.cl});
	assign is_right = d_x >= $signed({1'b0, cfg.cr});

	logic          vld_s1, vld_s2, vld_s3, vld_s4;
	logic [1:0]    reg_s1, reg_s2, reg_s3, reg_s4;
	logic [31:0]   k_s1;
	logic [63:0]   b_s1, b_s2, b_s3;
	logic [QW-1:0] t_s1;
	logic          big_s1, big_s2, big_s3;
	logic [63:0]   phi_s2;
	logic [QW-1:0] plo_s2;
	logic [61:0]   tsq_s2;
	logic [64:0]   epre_s3;
	logic [F+5:0]  e_s4;
	logic          uf_s4;

	logic [64:0] e_full;
	logic        uf_nx;

	always_comb begin
		if (reg_s3 == REGION_CORE) begin
			e_full = epre_s3;
		end else if (epre_s3 > 65'(b_s3)) begin
			e_full = epre_s3 - 65'(b_s3);
		end else begin
			e_full = '0;
		end
		uf_nx = ((reg_s3 == REGION_CORE) && big_s3) || (e_full >= LIMIT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (is_left) begin
			reg_s1 <= REGION_LEFT;
			k_s1   <= cfg.kl;
			b_s1   <= cfg.bl;
		end else begin
			reg_s1 <= is_right ? REGION_RIGHT : REGION_CORE;
			k_s1   <= cfg.kr;
			b_s1   <= cfg.br;
		end
		t_s1   <= in_t;
		big_s1 <= |in_t[QW-1:31];

		// tail needs floor(k*t / 2^F), split at the binary point
		phi_s2 <= 64'(k_s1) * 64'(t_s1[QW-1:F]);
		plo_s2 <= QW'(k_s1) * QW'(t_s1[F-1:0]);
		tsq_s2 <= 62'(t_s1[30:0]) * 62'(t_s1[30:0]);
		reg_s2 <= reg_s1;
		b_s2   <= b_s1;
		big_s2 <= big_s1;

		if (reg_s2 == REGION_CORE) begin
			epre_s3 <= 65'(tsq_s2 >> (F + 1));
		end else begin
			epre_s3 <= 65'(phi_s2) + 65'(plo_s2 >> F);
		end
		reg_s3 <= reg_s2;
		b_s3   <= b_s2;
		big_s3 <= big_s2;

		e_s4   <= e_full[F+5:0];
		uf_s4  <= uf_nx;
		reg_s4 <= reg_s3;
	end

	assign out_valid  = vld_s4;
	assign out_e      = e_s4;
	assign out_uf     = uf_s4;
	assign out_region = reg_s4;

endmodule

>>> design/egl_expneg.sv
// ----------------------------------------------------------------------------
// egl_expneg
// exp(-e): ln2 range reduction over six stages, 13-term series at three
// stages per term, then the final shift.
// ----------------------------------------------------------------------------
module egl_expneg import egl_pkg::*; #(
	parameter int F = 24
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	input  logic [F+5:0] in_e,
	input  logic         in_uf,
	input  logic [1:0]   in_region,
	output logic         out_valid,
	output logic [F:0]   out_v,
	output logic [1:0]   out_region
);

	localparam int RED_STEPS = 6;

	typedef struct packed {
		logic       uf;
		logic [1:0] region;
	} side_t;

	typedef struct packed {
		logic [37:0] rem;
		logic [5:0]  n;
	} red_t;

	typedef struct packed {
		logic [31:0] r;
		logic [5:0]  n;
		side_t       side;
		logic [33:0] sum;
	} tay_ctx_t;

	function automatic red_t red_step(red_t a, int j);
		red_t        o;
		logic [37:0] lj;
		lj = 38'(LN2_Q32) << j;
		o  = a;
		if (a.rem >= lj) begin
			o.rem  = a.rem - lj;
			o.n[j] = 1'b1;
		end
		return o;
	endfunction

	// range reduction: E = n*ln2 + r, one quotient bit a stage
	logic [37:0] e32;
	red_t        red_nx   [RED_STEPS];
	red_t        red_s    [RED_STEPS];
	side_t       side_s   [RED_STEPS];
	logic        red_vld_s[RED_STEPS];

	assign e32 = 38'(in_e) << (32 - F);

	always_comb begin
		red_nx[0] = red_step({e32, 6'd0}, RED_STEPS - 1);
		for (int i = 1; i < RED_STEPS; i++) begin
			red_nx[i] = red_step(red_s[i-1], RED_STEPS - 1 - i);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < RED_STEPS; i++) red_vld_s[i] <= 1'b0;
		end else begin
			red_vld_s[0] <= in_valid;
			for (int i = 1; i < RED_STEPS; i++) red_vld_s[i] <= red_vld_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		side_s[0] <= {in_uf, in_region};
		for (int i = 1; i < RED_STEPS; i++) side_s[i] <= side_s[i-1];
		for (int i = 0; i < RED_STEPS; i++) red_s[i] <= red_nx[i];
	end

	// series chain
	logic        c_vld [TAYLOR_TERMS];
	tay_ctx_t    c_ctx [TAYLOR_TERMS];
	logic [32:0] c_term[TAYLOR_TERMS];

	for (genvar g = 0; g < TAYLOR_TERMS; g++) begin : g_term
		localparam int K = g + 1;
		localparam logic [36:0] RECIP = 37'((64'd1 << RECIP_SHIFT) / K);
		localparam logic [32:0] KV = 33'(K);

		logic        vi;
		tay_ctx_t    ci;
		logic [32:0] ti;

		if (g == 0) begin : g_first
			assign vi = red_vld_s[RED_STEPS-1];
			assign ci = {red_s[RED_STEPS-1].rem[31:0], red_s[RED_STEPS-1].n,
				side_s[RED_STEPS-1], 34'h1_0000_0000};
			assign ti = 33'h1_0000_0000;
		end else begin : g_next
			assign vi = c_vld[g-1];
			assign ci = c_ctx[g-1];
			assign ti = c_term[g-1];
		end

		logic        vld_s1, vld_s2, vld_s3;
		tay_ctx_t    ctx_s1, ctx_s2, ctx_s3;
		logic [64:0] p_s1;
		logic [32:0] x_s2;
		logic [69:0] q_s2;
		logic [32:0] term_s3;

		// divide by K: reciprocal estimate is exact or one short
		logic [32:0] q0;
		logic [32:0] rr;
		logic [32:0] qf;

		assign q0 = q_s2[RECIP_SHIFT+32:RECIP_SHIFT];
		assign rr = x_s2 - q0 * KV;
		assign qf = (rr >= KV) ? q0 + 33'd1 : q0;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s1 <= 1'b0;
				vld_s2 <= 1'b0;
				vld_s3 <= 1'b0;
			end else begin
				vld_s1 <= vi;
				vld_s2 <= vld_s1;
				vld_s3 <= vld_s2;
			end
		end

		always_ff @(posedge clk) begin
			ctx_s1  <= ci;
			p_s1    <= 65'(ti) * 65'(ci.r);
			ctx_s2  <= ctx_s1;
			x_s2    <= p_s1[64:32];
			q_s2    <= 70'(p_s1[64:32]) * 70'(RECIP);
			ctx_s3.r    <= ctx_s2.r;
			ctx_s3.n    <= ctx_s2.n;
			ctx_s3.side <= ctx_s2.side;
			if (K % 2 == 1) begin
				ctx_s3.sum <= ctx_s2.sum - 34'(qf);
			end else begin
				ctx_s3.sum <= ctx_s2.sum + 34'(qf);
			end
			term_s3 <= qf;
		end

		assign c_vld[g]  = vld_s3;
		assign c_ctx[g]  = ctx_s3;
		assign c_term[g] = term_s3;
	end

	// scale by 2^-n and drop to F fraction bits
	tay_ctx_t    last;
	logic [33:0] sh;
	logic [33:0] sv;
	logic        vld_q;
	logic [F:0]  v_q;
	logic [1:0]  region_q;

	assign last = c_ctx[TAYLOR_TERMS-1];
	assign sh   = last.sum >> last.n;
	assign sv   = sh >> (32 - F);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= c_vld[TAYLOR_TERMS-1];
		end
	end

	always_ff @(posedge clk) begin
		v_q      <= last.side.uf ? '0 : sv[F:0];
		region_q <= last.side.region;
	end

	assign out_valid  = vld_q;
	assign out_v      = v_q;
	assign out_region = region_q;

endmodule

>>> design/exp_gauss_exp_lineshape_eval.sv
// ----------------------------------------------------------------------------
// exp_gauss_exp_lineshape_eval
// ExpGaussExp peak shape evaluator, fully pipelined.
// ----------------------------------------------------------------------------
// One sample is taken on every cycle that start is high; busy never rises.
// Each result appears with done high for one cycle; results come out in
// order and cannot be held off. The pipeline holds the bit-per-stage
// divider (32 + FRAC_BITS stages), six range-reduction stages and the
// 13-term series at three stages per term.
// Write the configuration registers only while no sample is in flight; a
// sample may start in the cycle after the last write.
`include "exp_gauss_exp_lineshape_eval_assert.svh"

module exp_gauss_exp_lineshape_eval import egl_pkg::*; #(
	parameter int FRAC_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] x_sample,
	output logic        done,
	output logic [38:0] shape_value,
	output logic [1:0]  region,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [39:0] cfg_data
);

	localparam int F  = FRAC_BITS;
	localparam int QW = 32 + F;
	localparam int LATENCY = QW + 53;
	localparam logic [64:0] FRAC_MASK = (65'd1 << F) - 65'd1;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// configuration registers
	logic [39:0] norm_gain_q;
	logic [31:0] peak_mean_q;
	logic [30:0] peak_sigma_q;
	logic [31:0] left_slope_q;
	logic [31:0] right_slope_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			norm_gain_q   <= 40'(64'd1 << F);
			peak_mean_q   <= '0;
			peak_sigma_q  <= 31'(64'd1 << F);
			left_slope_q  <= 32'(64'd1 << F);
			right_slope_q <= 32'(64'd1 << F);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_NORM_GAIN:   norm_gain_q   <= cfg_data;
				CFG_PEAK_MEAN:   peak_mean_q   <= cfg_data[31:0];
				CFG_PEAK_SIGMA:  peak_sigma_q  <= cfg_data[30:0];
				CFG_LEFT_SLOPE:  left_slope_q  <= cfg_data[31:0];
				CFG_RIGHT_SLOPE: right_slope_q <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	// derived values, two register layers, first used deep in the pipe
	logic [30:0] sig_eff;
	logic [31:0] kl_mag, kr_mag;

	assign sig_eff = (peak_sigma_q == '0) ? 31'd1 : peak_sigma_q;
	assign kl_mag  = left_slope_q[31] ? -left_slope_q : left_slope_q;
	assign kr_mag  = right_slope_q[31] ? -right_slope_q : right_slope_q;

	logic [31:0]    kl_q, kr_q;
	logic [62:0]    kl_sig_q, kr_sig_q;
	logic [63:0]    kl_sq_q, kr_sq_q;
	egl_shape_cfg_t shape_cfg_q;

	always_ff @(posedge clk) begin
		kl_q     <= kl_mag;
		kr_q     <= kr_mag;
		kl_sig_q <= 63'(kl_mag) * 63'(sig_eff);
		kr_sig_q <= 63'(kr_mag) * 63'(sig_eff);
		kl_sq_q  <= 64'(kl_mag) * 64'(kl_mag);
		kr_sq_q  <= 64'(kr_mag) * 64'(kr_mag);

		shape_cfg_q.kl <= kl_q;
		shape_cfg_q.kr <= kr_q;
		shape_cfg_q.cl <= 64'((65'(kl_sig_q) + FRAC_MASK) >> F);
		shape_cfg_q.cr <= 64'((65'(kr_sig_q) + FRAC_MASK) >> F);
		shape_cfg_q.bl <= kl_sq_q >> (F + 1);
		shape_cfg_q.br <= kr_sq_q >> (F + 1);
	end

	// input stage: offset from the mean
	logic        vld_s1;
	logic [32:0] d_s1;
	logic [32:0] nd;
	logic [31:0] ad;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		d_s1 <= 33'(signed'(x_sample)) - 33'(signed'(peak_mean_q));
	end

	assign nd = -d_s1;
	assign ad = d_s1[32] ? nd[31:0] : d_s1[31:0];

	logic          div_vld;
	logic [QW-1:0] div_t;
	logic [32:0]   div_d;

	egl_div #(.F(F)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vld_s1),
		.in_ad    (ad),
		.in_d     (d_s1),
		.sigma    (sig_eff),
		.out_valid(div_vld),
		.out_t    (div_t),
		.out_d    (div_d)
	);

	logic         ex_vld;
	logic [F+5:0] ex_e;
	logic         ex_uf;
	logic [1:0]   ex_region;

	egl_expo #(.F(F)) u_expo (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (div_vld),
		.in_t      (div_t),
		.in_d      (div_d),
		.cfg       (shape_cfg_q),
		.out_valid (ex_vld),
		.out_e     (ex_e),
		.out_uf    (ex_uf),
		.out_region(ex_region)
	);

	logic       en_vld;
	logic [F:0] en_v;
	logic [1:0] en_region;

	egl_expneg #(.F(F)) u_expneg (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (ex_vld),
		.in_e      (ex_e),
		.in_uf     (ex_uf),
		.in_region (ex_region),
		.out_valid (en_vld),
		.out_v     (en_v),
		.out_region(en_region)
	);

	// normalization, split at the binary point of the gain
	logic          nrm_pos;
	logic          nrm_vld_s1, nrm_vld_s2;
	logic [39:0]   nrm_hi_s1;
	logic [2*F:0]  nrm_lo_s1;
	logic [F:0]    nrm_v_s1;
	logic [1:0]    nrm_reg_s1, nrm_reg_s2;
	logic [38:0]   nrm_res_s2;
	logic [39:0]   nrm_sum;

	assign nrm_pos = !norm_gain_q[39] && (|norm_gain_q[38:0]);
	assign nrm_sum = nrm_pos ? nrm_hi_s1 + 40'(nrm_lo_s1 >> F) : 40'(nrm_v_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nrm_vld_s1 <= 1'b0;
			nrm_vld_s2 <= 1'b0;
		end else begin
			nrm_vld_s1 <= en_vld;
			nrm_vld_s2 <= nrm_vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		nrm_hi_s1  <= 40'(en_v) * 40'(norm_gain_q[38:F]);
		nrm_lo_s1  <= (2*F+1)'(en_v) * (2*F+1)'(norm_gain_q[F-1:0]);
		nrm_v_s1   <= en_v;
		nrm_reg_s1 <= en_region;
		nrm_res_s2 <= nrm_sum[38:0];
		nrm_reg_s2 <= nrm_reg_s1;
	end

	assign done        = nrm_vld_s2;
	assign shape_value = nrm_res_s2;
	assign region      = nrm_reg_s2;

	`EGL_ASSERT(a_latency, (start && !busy) |-> ##LATENCY done)
	`EGL_ASSERT(a_no_spurious, done |-> $past(start && !busy, LATENCY))
	`EGL_ASSERT_NEVER(a_region_code, done && region > REGION_RIGHT)
	`EGL_ASSERT_NEVER(a_unit_peak, done && !nrm_pos && shape_value > 39'(64'd1 << F))

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives sample beats and register writes into the ExpGaussExp evaluator and
// checks every result against an in-bench fixed-point line shape predictor.
// ----------------------------------------------------------------------------
module testbench;
	import egl_pkg::*;

	localparam int FRAC    = 24;
	localparam int LATENCY = FRAC + 85;
	localparam int WDOG    = 4000;
	localparam longint unsigned LN2    = 64'd2977044471;
	localparam longint unsigned MULCAP = 64'd1 << 62;

	typedef enum logic [1:0] {OP_SAMPLE, OP_CFG, OP_DRAIN} op_kind_t;
	typedef struct {
		op_kind_t    kind;
		logic [2:0]  idx;
		logic [39:0] data;
	} op_t;
	typedef struct {
		logic [38:0] value;
		logic [1:0]  rgn;
	} shape_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [31:0] x_sample = '0;
	logic        done;
	logic [38:0] shape_value;
	logic [1:0]  region;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [39:0] cfg_data = '0;

	// predictor copy of the registers
	logic [39:0] m_norm  = 40'd1 << FRAC;
	logic [31:0] m_mean  = '0;
	logic [30:0] m_sigma = 31'd1 << FRAC;
	logic [31:0] m_kl    = 32'd1 << FRAC;
	logic [31:0] m_kr    = 32'd1 << FRAC;

	op_t    pending_ops[$];
	shape_t expected_shapes[$];
	int     n_samples = 0, n_results = 0, n_writes = 0, n_errors = 0;
	int     n_rgn[3] = '{0, 0, 0};
	int     quiet = 0;
	longint cycle = 0;

	exp_gauss_exp_lineshape_eval #(.FRAC_BITS(FRAC)) uut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint unsigned mag32(logic [31:0] v);
		longint s;
		s = longint'($signed(v));
		return s < 0 ? longint'(-s) : longint'(s);
	endfunction

	function automatic longint unsigned tail_exp(longint unsigned k, longint unsigned t);
		longint unsigned hi, lo, a, b;
		hi = t >> FRAC;
		lo = t & ((64'd1 << FRAC) - 1);
		if (k == 0) a = 0;
		else if (hi > MULCAP / k) a = MULCAP;
		else begin
			a = k * hi + ((k * lo) >> FRAC);
			if (a > MULCAP) a = MULCAP;
		end
		b = (k * k) >> (FRAC + 1);
		return a > b ? a - b : 0;
	endfunction

	function automatic longint unsigned exp_neg(longint unsigned e);
		longint unsigned e32, n, r, sum, term;
		if (e >= (longint'(EXP_LIMIT) << FRAC)) return 0;
		e32 = e << (32 - FRAC);
		n = e32 / LN2;
		r = e32 - n * LN2;
		sum = 64'd1 << 32;
		term = 64'd1 << 32;
		for (int k = 1; k <= TAYLOR_TERMS; k++) begin
			term = ((term * r) >> 32) / k;
			if (k % 2) sum -= term;
			else sum += term;
		end
		return (sum >> n) >> (32 - FRAC);
	endfunction

	function automatic shape_t predict_shape(logic [31:0] x);
		longint d, ng;
		longint unsigned s, kl, kr, ad, q, rm, t, e, v, res, nn;
		shape_t o;
		d = longint'($signed(x)) - longint'($signed(m_mean));
		s = (m_sigma == 0) ? 1 : longint'(m_sigma);
		kl = mag32(m_kl);
		kr = mag32(m_kr);
		ad = d < 0 ? -d : d;
		q = ad / s;
		rm = ad % s;
		t = (q << FRAC) + ((rm << FRAC) / s);
		if (-d >= longint'((kl * s + ((64'd1 << FRAC) - 1)) >> FRAC)) begin
			o.rgn = REGION_LEFT;
			e = tail_exp(kl, t);
		end else if (d >= longint'((kr * s + ((64'd1 << FRAC) - 1)) >> FRAC)) begin
			o.rgn = REGION_RIGHT;
			e = tail_exp(kr, t);
		end else begin
			o.rgn = REGION_CORE;
			e = (t >= (64'd1 << 31)) ? (longint'(EXP_LIMIT) << FRAC) : (t * t) >> (FRAC + 1);
		end
		v = exp_neg(e);
		ng = longint'($signed(m_norm));
		if (ng > 0) begin
			nn = ng;
			res = v * (nn >> FRAC) + ((v * (nn & ((64'd1 << FRAC) - 1))) >> FRAC);
		end else res = v;
		o.value = res[38:0];
		return o;
	endfunction

	// driver: one op in flight, pops the next when the current beat is done
	always @(posedge clk or negedge arst_n) begin
		bit          fin, idle_ok;
		logic        nstart, nvalid;
		logic [31:0] nx;
		logic [2:0]  ni;
		logic [39:0] nd;
		if (!arst_n) begin
			start <= 1'b0;
			cfg_valid <= 1'b0;
		end else begin
			cycle++;
			if (start && !busy) begin
				expected_shapes.push_back(predict_shape(x_sample));
				n_samples++;
			end
			if (cfg_valid && cfg_ready) begin
				n_writes++;
				case (cfg_index)
					CFG_NORM_GAIN:   m_norm = cfg_data;
					CFG_PEAK_MEAN:   m_mean = cfg_data[31:0];
					CFG_PEAK_SIGMA:  m_sigma = cfg_data[30:0];
					CFG_LEFT_SLOPE:  m_kl = cfg_data[31:0];
					CFG_RIGHT_SLOPE: m_kr = cfg_data[31:0];
					default: ;
				endcase
			end
			fin = !(start && busy) && !(cfg_valid && !cfg_ready);
			nstart = start; nvalid = cfg_valid; nx = x_sample; ni = cfg_index; nd = cfg_data;
			if (fin) begin
				nstart = 1'b0;
				nvalid = 1'b0;
				// no random idle gaps in the middle of the run
				idle_ok = !(n_samples > 700 && n_samples < 1000);
				if (pending_ops.size() > 0) begin
					case (pending_ops[0].kind)
						OP_DRAIN: begin
							if (expected_shapes.size() == 0 && quiet >= 4)
								void'(pending_ops.pop_front());
						end
						OP_CFG: begin
							nvalid = 1'b1;
							ni = pending_ops[0].idx;
							nd = pending_ops[0].data;
							void'(pending_ops.pop_front());
						end
						default: begin
							if (!(idle_ok && $urandom_range(99) < 12)) begin
								nstart = 1'b1;
								nx = pending_ops[0].data[31:0];
								void'(pending_ops.pop_front());
							end
						end
					endcase
				end
			end
			start <= nstart;
			cfg_valid <= nvalid;
			x_sample <= nx;
			cfg_index <= ni;
			cfg_data <= nd;
		end
	end

	// monitor: results cannot be held off, so every done beat is checked
	always @(posedge clk) begin
		shape_t exp_s;
		if (arst_n && done) begin
			n_results++;
			if (expected_shapes.size() == 0) begin
				$error("result with nothing expected: shape_value %0d region %0d",
					shape_value, region);
				n_errors++;
			end else begin
				exp_s = expected_shapes.pop_front();
				if (region <= REGION_RIGHT) n_rgn[region]++;
				if (shape_value !== exp_s.value) begin
					$error("shape_value expected %0d actual %0d", exp_s.value, shape_value);
					n_errors++;
				end
				if (region !== exp_s.rgn) begin
					$error("region expected %0d actual %0d", exp_s.rgn, region);
					n_errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || (cfg_valid && cfg_ready) || done) quiet = 0;
		else quiet++;
		if (quiet >= WDOG) begin
			$display("timeout after %0d idle cycles", quiet);
			$display("testbench NOT OK");
			$finish;
		end
	end

	task automatic push_sample(logic [31:0] x);
		op_t o;
		o.kind = OP_SAMPLE; o.idx = '0; o.data = {8'd0, x};
		pending_ops.push_back(o);
	endtask

	task automatic push_drain();
		op_t o;
		o.kind = OP_DRAIN; o.idx = '0; o.data = '0;
		pending_ops.push_back(o);
	endtask

	task automatic push_setting(logic [39:0] n, logic [31:0] m, logic [30:0] s,
			logic [31:0] l, logic [31:0] r);
		op_t o;
		push_drain();
		o.kind = OP_CFG;
		o.idx = CFG_NORM_GAIN;   o.data = n;               pending_ops.push_back(o);
		o.idx = CFG_PEAK_MEAN;   o.data = {8'd0, m};       pending_ops.push_back(o);
		o.idx = CFG_PEAK_SIGMA;  o.data = {9'd0, s};       pending_ops.push_back(o);
		o.idx = CFG_LEFT_SLOPE;  o.data = {8'd0, l};       pending_ops.push_back(o);
		o.idx = CFG_RIGHT_SLOPE; o.data = {8'd0, r};       pending_ops.push_back(o);
	endtask

	// random sample, mostly within a few widths of the peak
	function automatic logic [31:0] rand_x(logic [31:0] m, logic [30:0] s);
		longint off;
		if ($urandom_range(99) < 20) return $urandom;
		off = (longint'($signed($urandom)) * longint'(s)) >>> 29;
		return 32'(longint'($signed(m)) + off);
	endfunction

	task automatic random_phase(int count, logic [31:0] m, logic [30:0] s);
		for (int i = 0; i < count; i++) begin
			push_sample(rand_x(m, s));
			if (i == count / 2) push_drain();
		end
	endtask

	initial begin
		logic [39:0] n;
		logic [31:0] m, l, r;
		logic [30:0] s;
		logic [31:0] dir_x [10];
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset setting, field extremes and region boundaries
		dir_x = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff, 32'h0100_0000,
			32'hff00_0000, 32'h0100_0001, 32'hfeff_ffff, 32'h0200_0000,
			32'h0080_0000};
		foreach (dir_x[i])
			push_sample(dir_x[i]);
		// zero slopes, zero sigma, nonpositive gain
		push_setting(40'h80_0000_0000, 32'h0, 31'd0, 32'h0, 32'h0);
		push_sample(32'h0); push_sample(32'hffff_ffff); push_sample(32'h1);
		push_sample(32'h8000_0000);
		// max gain, extreme slopes and sigma (huge tail products)
		push_setting(40'h7f_ffff_ffff, 32'h8000_0000, 31'h7fff_ffff, 32'h8000_0000,
			32'h7fff_ffff);
		push_sample(32'h7fff_ffff); push_sample(32'h8000_0000); push_sample(32'h0);
		push_setting(40'h0, 32'h7fff_ffff, 31'd1, 32'h0100_0000, 32'hff00_0000);
		push_sample(32'h7fff_ffff); push_sample(32'h7fff_fffe); push_sample(32'h8000_0000);
		push_sample(32'h7fff_fff0);

		random_phase(200, 32'h7fff_ffff, 31'd1);
		for (int p = 0; p < 7; p++) begin
			n = 40'({$urandom, $urandom});
			if (p == 1) n = 40'd0;
			if (p == 2) n = 40'd1 << FRAC;
			m = (p % 2) ? $urandom : 32'($signed($urandom_range(255)) - 128) << 20;
			s = (p == 3) ? 31'h7fff_ffff : 31'($urandom_range(32'h0400_0000, 1) | (p == 5));
			l = (p == 4) ? 32'h0 :
				($urandom >> $urandom_range(8, 0)) ^ {32{1'($urandom_range(1))}};
			r = (p == 6) ? 32'h8000_0000 : $urandom >> $urandom_range(8, 0);
			push_setting(n, m, s, l, r);
			random_phase(220, m, s);
		end

		wait (pending_ops.size() == 0 && expected_shapes.size() == 0);
		repeat (LATENCY + 20) @(posedge clk);
		$display("%0d samples, %0d results, %0d register writes", n_samples, n_results,
			n_writes);
		$display("regions seen: core %0d, left tail %0d, right tail %0d",
			n_rgn[0], n_rgn[1], n_rgn[2]);
		if (n_errors == 0 && expected_shapes.size() == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end
endmodule
